### sv/assert_macros.svh
// assertion shorthands, all sampled on the rising edge of clk and off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that must hold at every clock edge
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// if the antecedent holds, the consequent must hold in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tss_pkg.sv
package tss_pkg;

  localparam int CHANNELS_DEF     = 2;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int ST_W    = 24;        // per-channel state width
  localparam int MUL_W   = 25;        // shared multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int MIXD_W  = 40;        // dry product
  localparam int ACC_W   = 57;        // mix accumulator at 2^-38 scale
  localparam int ADDR_W  = 5;
  localparam int PDATA_W = 32;
  localparam int USER_W  = 2;
  localparam int COEF_W  = 17;        // q1.15 coefficient capped at one

  localparam logic signed [MUL_W-1:0] ONE_Q23     = 25'sd8388608;
  localparam logic signed [MUL_W-1:0] NEG_ONE_Q23 = -25'sd8388608;
  localparam logic signed [MUL_W-1:0] C_THIRD_Q23 = 25'sd2796200;
  localparam logic signed [MUL_W-1:0] C_FIFTH_Q23 = 25'sd1118479;
  localparam logic [COEF_W-1:0]       ONE_Q15     = 17'd32768;

  localparam logic signed [63:0] ST_MAX = 64'sd8388607;
  localparam logic signed [63:0] ST_MIN = -64'sd8388608;

  localparam logic        ENABLE_RST   = 1'b0;
  localparam logic [14:0] DRIVE_RST    = 15'd4096;
  localparam logic [12:0] BIAS_RST     = 13'd0;
  localparam logic [15:0] WET_RST      = 16'd0;
  localparam logic [15:0] LOWPASS_RST  = 16'd4915;
  localparam logic [15:0] DCBLOCK_RST  = 16'd32604;

  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_DRIVE,
    REG_BIAS,
    REG_WET,
    REG_LOWPASS,
    REG_DCBLOCK
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LP,
    S_DRV,
    S_SQA,
    S_SQB,
    S_PA,
    S_PB,
    S_QA,
    S_QB,
    S_SHA,
    S_SHB,
    S_DC,
    S_MIXD,
    S_MIXW,
    S_DONE
  } state_t;

  // arithmetic shift right, rounding half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > ST_MAX) c = ST_MAX;
    else if (v < ST_MIN) c = ST_MIN;
    else c = v;
    return ST_W'(c);
  endfunction

  function automatic logic [COEF_W-1:0] cap_one(input logic [15:0] c);
    return (COEF_W'(c) > ONE_Q15) ? ONE_Q15 : COEF_W'(c);
  endfunction

endpackage

### sv/tube_saturation_stage_unit.sv
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------------
// s_*      | in        | s_tvalid / s_tready        | s_tdata: sample_in; s_tuser: channel
// m_*      | out       | m_tvalid / m_tready        | m_tdata: sample_out
// apb      | in        | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// from acceptance to the output register a sample passes through the accept cycle,
//   13 steps of the single shared 25x25 multiplier (one product per sequencer step)
//   and one output step; s_tready is high again in the cycle after that
// with enable low a sample is copied through and no channel state changes
// rst (synchronous) restores the register defaults, zeroes all channel state and
//   empties the output register
// a result waiting in the output register does not block acceptance; the sequencer
//   only holds in its output step while the register is full and m_tready is low
`include "assert_macros.svh"

module tube_saturation_stage_unit #(
  parameter int CHANNELS     = tss_pkg::CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = tss_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
  input  logic [tss_pkg::USER_W-1:0]             s_tuser,   // [1:0] channel
  // output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
  // register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tss_pkg::ADDR_W-1:0]             paddr,
  input  logic [tss_pkg::PDATA_W-1:0]            pwdata,
  output logic [tss_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready
);
  import tss_pkg::*;

  localparam int DW     = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int XS_SH  = ST_W - SAMPLE_WIDTH;       // sample to q1.23
  localparam int OUT_SH = 39 - SAMPLE_WIDTH;         // 2^-38 scale back to sample scale
  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

  // configuration registers
  logic        enable;
  logic [14:0] drive_gain;
  logic [12:0] bias_offset;
  logic [15:0] wet_mix;
  logic [15:0] lowpass_coeff;
  logic [15:0] dc_block_coeff;

  // per-channel state
  logic signed [ST_W-1:0] lp_mem   [CHANNELS];
  logic signed [ST_W-1:0] prev_mem [CHANNELS];
  logic signed [ST_W-1:0] dcl_mem  [CHANNELS];

  state_t state, state_next;

  // working registers of the current sample
  logic                           bypass;
  logic [CW-1:0]                  ch;
  logic signed [SAMPLE_WIDTH-1:0] x_raw;
  logic signed [ST_W-1:0]         xs;
  logic signed [MUL_W-1:0]        d;
  logic signed [ST_W-1:0]         lp_w;
  logic signed [MUL_W-1:0]        xa, xb;       // shaper inputs: bias alone, driven signal
  logic                           clip_hi, clip_lo;
  logic signed [MUL_W-1:0]        x2a, x2b;
  logic signed [MUL_W-1:0]        ta, tb;       // polynomial term, p then q
  logic signed [MUL_W-1:0]        sha, shb;
  logic signed [ST_W-1:0]         shaped;
  logic signed [MUL_W-1:0]        rdc;
  logic signed [ST_W-1:0]         y;
  logic signed [MIXD_W-1:0]       mixd;
  logic signed [ACC_W-1:0]        acc;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [63:0]       prod_w;
  logic signed [63:0]       r23;

  logic [COEF_W-1:0] lp_c, dc_c, wet_c, dry_c;
  logic signed [MUL_W-1:0] bias_q23;

  logic                           in_xfer;
  logic [CW-1:0]                  ch_in;
  logic signed [SAMPLE_WIDTH-1:0] x_in;
  logic signed [ST_W-1:0]         xs_in;
  logic signed [63:0]             drv_r;
  logic signed [ST_W-1:0]         y_next;
  logic signed [63:0]             out_r;
  logic [SAMPLE_WIDTH-1:0]        out_u;
  logic                           out_load;
  logic                           cfg_wr;

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= ENABLE_RST;
      drive_gain     <= DRIVE_RST;
      bias_offset    <= BIAS_RST;
      wet_mix        <= WET_RST;
      lowpass_coeff  <= LOWPASS_RST;
      dc_block_coeff <= DCBLOCK_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_ENABLE:  enable         <= pwdata[0];
        REG_DRIVE:   drive_gain     <= pwdata[14:0];
        REG_BIAS:    bias_offset    <= pwdata[12:0];
        REG_WET:     wet_mix        <= pwdata[15:0];
        REG_LOWPASS: lowpass_coeff  <= pwdata[15:0];
        REG_DCBLOCK: dc_block_coeff <= pwdata[15:0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ENABLE:  prdata = PDATA_W'(enable);
      REG_DRIVE:   prdata = PDATA_W'(drive_gain);
      REG_BIAS:    prdata = PDATA_W'(bias_offset);
      REG_WET:     prdata = PDATA_W'(wet_mix);
      REG_LOWPASS: prdata = PDATA_W'(lowpass_coeff);
      REG_DCBLOCK: prdata = PDATA_W'(dc_block_coeff);
      default:     prdata = '0;
    endcase
  end

  // coefficients above one act as one
  assign lp_c     = cap_one(lowpass_coeff);
  assign dc_c     = cap_one(dc_block_coeff);
  assign wet_c    = cap_one(wet_mix);
  assign dry_c    = ONE_Q15 - wet_c;
  assign bias_q23 = $signed(MUL_W'({bias_offset, 8'd0}));

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid & s_tready;
  assign x_in     = $signed(s_tdata[SAMPLE_WIDTH-1:0]);
  assign xs_in    = ST_W'(x_in) <<< XS_SH;

  // channels past the last one fold onto channel 0
  always_comb begin
    if (32'(s_tuser) >= CHANNELS) ch_in = '0;
    else ch_in = CW'(s_tuser);
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state and multiplier operands
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = enable ? S_LP : S_DONE;
      end
      S_LP: begin
        mul_a      = d;
        mul_b      = $signed(MUL_W'(lp_c));
        state_next = S_DRV;
      end
      S_DRV: begin
        mul_a      = MUL_W'(lp_w);
        mul_b      = $signed(MUL_W'(drive_gain));
        state_next = S_SQA;
      end
      S_SQA: begin
        mul_a      = xa;
        mul_b      = xa;
        state_next = S_SQB;
      end
      S_SQB: begin
        mul_a      = xb;
        mul_b      = xb;
        state_next = S_PA;
      end
      S_PA: begin
        mul_a      = x2a;
        mul_b      = C_FIFTH_Q23;
        state_next = S_PB;
      end
      S_PB: begin
        mul_a      = x2b;
        mul_b      = C_FIFTH_Q23;
        state_next = S_QA;
      end
      S_QA: begin
        mul_a      = x2a;
        mul_b      = ta;
        state_next = S_QB;
      end
      S_QB: begin
        mul_a      = x2b;
        mul_b      = tb;
        state_next = S_SHA;
      end
      S_SHA: begin
        mul_a      = xa;
        mul_b      = ta;
        state_next = S_SHB;
      end
      S_SHB: begin
        mul_a      = xb;
        mul_b      = tb;
        state_next = S_DC;
      end
      S_DC: begin
        mul_a      = MUL_W'(dcl_mem[ch]);
        mul_b      = $signed(MUL_W'(dc_c));
        state_next = S_MIXD;
      end
      S_MIXD: begin
        mul_a      = MUL_W'(xs);
        mul_b      = $signed(MUL_W'(dry_c));
        state_next = S_MIXW;
      end
      S_MIXW: begin
        mul_a      = MUL_W'(y);
        mul_b      = $signed(MUL_W'(wet_c));
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  assign prod   = mul_a * mul_b;
  assign prod_w = 64'(prod);
  assign r23    = rnd_shift(prod_w, 23);

  // drive gain plus bias offset, before the clip
  assign drv_r  = rnd_shift(prod_w, 12) + 64'(bias_q23);

  // dc blocker: y = x - x_prev + R * y_prev, saturated
  assign y_next = sat_st(64'(shaped) - 64'(prev_mem[ch]) + 64'(rdc));

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          bypass <= ~enable;
          ch     <= ch_in;
          x_raw  <= x_in;
          xs     <= xs_in;
          d      <= MUL_W'(xs_in) - MUL_W'(lp_mem[ch_in]);
          xa     <= bias_q23;
        end
      end
      S_LP: lp_w <= sat_st(64'(lp_mem[ch]) + rnd_shift(prod_w, 15));
      S_DRV: begin
        // hard limit outside +-1, the polynomial is used up to and including it
        clip_hi <= (drv_r > 64'(ONE_Q23));
        clip_lo <= (drv_r < 64'(NEG_ONE_Q23));
        if (drv_r > 64'(ONE_Q23)) xb <= ONE_Q23;
        else if (drv_r < 64'(NEG_ONE_Q23)) xb <= NEG_ONE_Q23;
        else xb <= MUL_W'(drv_r);
      end
      S_SQA: x2a <= MUL_W'(r23);
      S_SQB: x2b <= MUL_W'(r23);
      S_PA:  ta  <= MUL_W'(r23) - C_THIRD_Q23;
      S_PB:  tb  <= MUL_W'(r23) - C_THIRD_Q23;
      S_QA:  ta  <= ONE_Q23 + MUL_W'(r23);
      S_QB:  tb  <= ONE_Q23 + MUL_W'(r23);
      S_SHA: sha <= MUL_W'(r23);
      S_SHB: begin
        if (clip_hi) shb <= ONE_Q23;
        else if (clip_lo) shb <= NEG_ONE_Q23;
        else shb <= MUL_W'(r23);
      end
      S_DC: begin
        rdc    <= MUL_W'(rnd_shift(prod_w, 15));
        shaped <= ST_W'(rnd_shift(64'(shb) - 64'(sha), 1));
      end
      S_MIXD: begin
        mixd <= MIXD_W'(prod);
        y    <= y_next;
      end
      S_MIXW: acc <= ACC_W'((64'(mixd) <<< 16) + (prod_w <<< 1));
      default: ;
    endcase
  end

  // channel state is written back once per enabled sample
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lp_mem[i]   <= '0;
        prev_mem[i] <= '0;
        dcl_mem[i]  <= '0;
      end
    end else if (state == S_MIXD) begin
      lp_mem[ch]   <= lp_w;
      prev_mem[ch] <= shaped;
      dcl_mem[ch]  <= y_next;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  assign out_r    = rnd_shift(64'(acc), OUT_SH);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    if (bypass) out_u = x_raw;
    else if (out_r > OUT_MAX) out_u = SAMPLE_WIDTH'(OUT_MAX);
    else if (out_r < OUT_MIN) out_u = SAMPLE_WIDTH'(OUT_MIN);
    else out_u = SAMPLE_WIDTH'(out_r);
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= DW'(out_u);
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // clip flags are only meaningful once the drive step has run, checked in the last shaper step
  `ASSERT_NEXT(a_valid_from_done, !m_tvalid, !m_tvalid || $past(state) == S_DONE, "stray result")
  `ASSERT_NEXT(a_done_holds, state == S_DONE && m_tvalid && !m_tready, state == S_DONE, "left early")
  `ASSERT_CLK(a_clip_excl, state != S_SHB || !(clip_hi && clip_lo), "clipped both ways")
  `ASSERT_NEXT(a_enabled_starts, in_xfer && enable, state == S_LP, "lowpass step not started")

endmodule

### tb/sv/tb_tube_saturation_stage_unit.sv
module tb_tube_saturation_stage_unit;
  import tss_pkg::*;

  // channel count of the instance and fixed-point constants of the shaper
  localparam int     CH_COUNT  = 2;
  localparam longint UNITY_Q23 = 64'sd8388608;
  localparam longint THIRD_Q23 = 64'sd2796200;
  localparam longint FIFTH_Q23 = 64'sd1118479;
  localparam longint LEVEL_MAX = 64'sd8388607;
  localparam longint LEVEL_MIN = -64'sd8388608;
  localparam longint COEF_UNITY = 64'sd32768;

  // register indexes that decode to nothing, the block must ignore writes there
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // timing of the run
  localparam int SETTLE_CYCLES   = 24;
  localparam int TAIL_CYCLES     = 40;
  localparam int CYCLE_LIMIT     = 800000;
  localparam int CONFIG_ROUNDS   = 16;
  localparam int ITEMS_PER_ROUND = 96;
  localparam int REPORT_LINES    = 40;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef enum {ROUND_LOW, ROUND_HIGH, ROUND_TYPICAL, ROUND_RAW} round_kind_t;

  // one line of the directed table: a register write or a sample transaction
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  sel;
    logic [31:0] wr_value;
    logic [15:0] smp;
    logic [1:0]  ch;
    logic        typed;       // expected sample typed in below instead of predicted
    logic [15:0] typed_out;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 40;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // disabled after reset: samples come back untouched on every channel
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h8000, 2'd0, 1'b1, 16'h8000},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h7FFF, 2'd1, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h0000, 2'd2, 1'b1, 16'h0000},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'hFFFF, 2'd3, 1'b1, 16'hFFFF},
    // write to an undecoded index, then a transparent lowpass at unity drive
    '{ROW_WRITE,  REG_SPARE_A, 32'hFFFF_FFFF, 16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_ENABLE,  32'd1,     16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_LOWPASS, 32'd32768, 16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_DRIVE,   32'd4096,  16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_BIAS,    32'd0,     16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_WET,     32'd32768, 16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_DCBLOCK, 32'd32604, 16'h0, 2'd0, 1'b0, 16'h0},
    // negative full scale puts the shaper input exactly on minus one
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h8000, 2'd0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h7FFF, 2'd1, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h0000, 2'd0, 1'b0, 16'h0},
    // drive of two: half scale hits plus one exactly, one lsb more clips
    '{ROW_WRITE,  REG_DRIVE,   32'd8192,  16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h4000, 2'd1, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h4001, 2'd1, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'hBFFF, 2'd0, 1'b0, 16'h0},
    // channels two and three fold onto channel zero
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h7FFF, 2'd2, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h8000, 2'd3, 1'b0, 16'h0},
    // coefficients above one, full bias and drive: blocker runs into its rails
    '{ROW_WRITE,  REG_WET,     32'hFFFF,  16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_LOWPASS, 32'hFFFF,  16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_DCBLOCK, 32'hFFFF,  16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_BIAS,    32'h1FFF,  16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_DRIVE,   32'h7FFF,  16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h7FFF, 2'd0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h7FFF, 2'd0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h8000, 2'd1, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h8000, 2'd0, 1'b0, 16'h0},
    // all dry at zero drive: the dry path overdrives the output range
    '{ROW_WRITE,  REG_WET,     32'd0,     16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_BIAS,    32'd0,     16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_DRIVE,   32'd0,     16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h1234, 2'd0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h8001, 2'd1, 1'b0, 16'h0},
    // disabled again, with state left over from above
    '{ROW_WRITE,  REG_ENABLE,  32'd0,     16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h1357, 2'd1, 1'b1, 16'h1357},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h8000, 2'd0, 1'b1, 16'h8000},
    // upper data bits are dropped, so enable stays low
    '{ROW_WRITE,  REG_SPARE_B, 32'h0,     16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_WRITE,  REG_ENABLE,  32'hFFFF_FFFE, 16'h0, 2'd0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_SPARE_A, 32'h0, 16'h7FFF, 2'd3, 1'b1, 16'h7FFF}
  };

  // block ports, every input known from time zero
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;     // [15:0] sample_in
  logic [1:0]  s_tuser  = '0;     // [1:0] channel
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [15:0] sample_out
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the registers, at their reset values
  logic        cfg_enable  = ENABLE_RST;
  logic [14:0] cfg_drive   = DRIVE_RST;
  logic [12:0] cfg_bias    = BIAS_RST;
  logic [15:0] cfg_wet     = WET_RST;
  logic [15:0] cfg_lowpass = LOWPASS_RST;
  logic [15:0] cfg_dcblock = DCBLOCK_RST;

  // predictor copy of the per-channel filter state
  longint lp_level    [CH_COUNT] = '{default: 0};
  longint shaped_prev [CH_COUNT] = '{default: 0};
  longint dc_level    [CH_COUNT] = '{default: 0};

  // samples still owed by the block, oldest first
  logic [15:0] expected_out [$];

  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 76;

  always #5 clk = ~clk;

  tube_saturation_stage_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // multiply-and-shift rounding, half away from zero
  function automatic longint round_shift(input longint v, input int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint clamp_level(input longint v);
    if (v > LEVEL_MAX) return LEVEL_MAX;
    if (v < LEVEL_MIN) return LEVEL_MIN;
    return v;
  endfunction

  // q1.15 coefficients saturate at one
  function automatic longint coef_cap(input logic [15:0] c);
    return (longint'(c) > COEF_UNITY) ? COEF_UNITY : longint'(c);
  endfunction

  // hard clip outside +-1, cubic-quintic curve inside, all in q1.23
  function automatic longint tube_curve(input longint v);
    longint sq;
    longint p;
    longint q;
    if (v > UNITY_Q23) return UNITY_Q23;
    if (v < -UNITY_Q23) return -UNITY_Q23;
    sq = round_shift(v * v, 23);
    p  = round_shift(sq * FIFTH_Q23, 23) - THIRD_Q23;
    q  = UNITY_Q23 + round_shift(sq * p, 23);
    return round_shift(v * q, 23);
  endfunction

  // one sample through lowpass, drive, shaper, dc blocker and dry/wet mix
  function automatic logic [15:0] tube_predict(input logic [15:0] raw, input logic [1:0] chan);
    longint x;
    longint lp;
    longint bias_q23;
    longint drive_in;
    longint shaped;
    longint y;
    longint m;
    longint acc;
    int     idx;
    if (!cfg_enable) return raw;
    x   = longint'($signed(raw));
    idx = (int'(chan) >= CH_COUNT) ? 0 : int'(chan);

    // lowpass in q1.23
    lp = lp_level[idx];
    lp = clamp_level(lp + round_shift((x * 256 - lp) * coef_cap(cfg_lowpass), 15));
    lp_level[idx] = lp;

    // asymmetric shaper, bias removed afterwards, result in q2.22
    bias_q23 = longint'(cfg_bias) * 256;
    drive_in = round_shift(lp * longint'(cfg_drive), 12) + bias_q23;
    shaped   = round_shift(tube_curve(drive_in) - tube_curve(bias_q23), 1);

    // dc blocker
    y = shaped - shaped_prev[idx] + round_shift(dc_level[idx] * coef_cap(cfg_dcblock), 15);
    y = clamp_level(y);
    shaped_prev[idx] = shaped;
    dc_level[idx]    = y;

    // mix at 2^-38 scale, back to sample scale and saturate
    m   = coef_cap(cfg_wet);
    acc = x * (COEF_UNITY - m) * 256 * 65536 + y * m * 2;
    acc = round_shift(acc, 23);
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (error_count < REPORT_LINES)
      $display("mismatch at cycle %0d: %s got %0d (%h) want %0d (%h)",
               cycle_count, what, $signed(got), got, $signed(want), want);
    error_count++;
  endtask

  // one sample transaction, with an optional idle gap before it
  task automatic push_sample(input logic [15:0] smp, input logic [1:0] ch,
                             input logic typed, input logic [15:0] typed_out);
    logic [15:0] predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= ch;
    do @(posedge clk); while (!s_tready);
    predicted = tube_predict(smp, ch);
    expected_out.push_back(typed ? typed_out : predicted);
  endtask

  // hold the input side until every owed sample has come out
  task automatic wait_results_drained(input int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_out.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // setup and access phase; the bus stays selected until released
  task automatic reg_write(input logic [2:0] sel, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      REG_ENABLE:  cfg_enable  = val[0];
      REG_DRIVE:   cfg_drive   = val[14:0];
      REG_BIAS:    cfg_bias    = val[12:0];
      REG_WET:     cfg_wet     = val[15:0];
      REG_LOWPASS: cfg_lowpass = val[15:0];
      REG_DCBLOCK: cfg_dcblock = val[15:0];
      default: ;
    endcase
  endtask

  task automatic bus_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // a fresh register setting: extremes, typical audio values or raw bus words
  task automatic apply_setting(input round_kind_t kind);
    logic [31:0] en_v;
    logic [31:0] drv_v;
    logic [31:0] bias_v;
    logic [31:0] wet_v;
    logic [31:0] lp_v;
    logic [31:0] dc_v;
    case (kind)
      ROUND_LOW: begin
        en_v = 1; drv_v = 0; bias_v = 0; wet_v = 0; lp_v = 0; dc_v = 0;
      end
      ROUND_HIGH: begin
        en_v = 1; drv_v = 32'h7FFF; bias_v = 32'h1FFF;
        wet_v = 32'hFFFF; lp_v = 32'hFFFF; dc_v = 32'hFFFF;
      end
      ROUND_RAW: begin
        en_v = $urandom; drv_v = $urandom; bias_v = $urandom;
        wet_v = $urandom; lp_v = $urandom; dc_v = $urandom;
      end
      default: begin
        en_v   = ($urandom_range(9) != 0);
        drv_v  = $urandom_range(20480, 4096);
        bias_v = $urandom_range(4915);
        wet_v  = $urandom_range(32768);
        lp_v   = $urandom_range(32768);
        dc_v   = $urandom_range(1) ? $urandom_range(32768, 32000) : $urandom_range(32768);
      end
    endcase
    wait_results_drained(SETTLE_CYCLES);
    reg_write(REG_ENABLE,  en_v);
    reg_write(REG_DRIVE,   drv_v);
    reg_write(REG_BIAS,    bias_v);
    reg_write(REG_WET,     wet_v);
    reg_write(REG_LOWPASS, lp_v);
    reg_write(REG_DCBLOCK, dc_v);
    if ($urandom_range(1)) reg_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    bus_release();
  endtask

  // output side: random back-pressure, every accepted transaction checked in order
  always @(posedge clk) begin : out_monitor
    logic [15:0] want;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          flag_mismatch("unexpected sample_out", m_tdata, 16'hxxxx);
        end else begin
          want = expected_out.pop_front();
          if (m_tdata !== want) flag_mismatch("sample_out", m_tdata, want);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit, several times the slowest legal run
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d samples outstanding",
             cycle_count, expected_out.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   row;
    logic        bus_held;
    logic [15:0] smp;
    logic [15:0] wander;
    logic [1:0]  ch;
    int          pick;
    round_kind_t kind;

    bus_held = 1'b0;
    wander   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table; writes only once the block has gone quiet
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_WRITE) begin
        if (!bus_held) wait_results_drained(SETTLE_CYCLES);
        reg_write(row.sel, row.wr_value);
        bus_held = 1'b1;
      end else begin
        if (bus_held) bus_release();
        bus_held = 1'b0;
        push_sample(row.smp, row.ch, row.typed, row.typed_out);
      end
    end

    // random rounds; receiver-heavy idling, then sender-heavy, then none
    for (int cfg_round = 0; cfg_round < CONFIG_ROUNDS; cfg_round++) begin
      if (cfg_round < 6) begin
        send_idle_pct = 14; recv_idle_pct = 76;
      end else if (cfg_round < 11) begin
        send_idle_pct = 76; recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      case (cfg_round % 8)
        0:       kind = ROUND_LOW;
        1:       kind = ROUND_HIGH;
        7:       kind = ROUND_RAW;
        default: kind = ROUND_TYPICAL;
      endcase
      apply_setting(kind);

      for (int n = 0; n < ITEMS_PER_ROUND; n++) begin
        // mid-round the sender waits for the pipeline to empty completely
        if (n == ITEMS_PER_ROUND / 2) wait_results_drained(0);
        pick = $urandom_range(99);
        if (pick < 10) begin
          smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        end else if (pick < 30) begin
          smp = 16'(int'($urandom_range(512)) - 256);
        end else if (pick < 55) begin
          // slowly wandering signal, so filters and blocker see real program
          wander = wander + 16'($urandom_range(2048)) - 16'd1024;
          smp    = wander;
        end else begin
          smp = 16'($urandom);
        end
        ch = 2'($urandom_range(3));
        push_sample(smp, ch, 1'b0, 16'h0000);
      end
    end

    // let the last transactions out, then watch for stray results
    wait_results_drained(TAIL_CYCLES);
    if (error_count == 0 && expected_out.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
